// ----- design/mlbf_pkg.sv -----
// ---------------------------------------------------------------------------
// mlbf_pkg
// Shared types, codes and layout tables of the meter LCD BCD formatter.
// ---------------------------------------------------------------------------
package mlbf_pkg;

    // One LCD digit code: 0-15 nibble value, 16 blank, 17 dash.
    typedef logic [4:0] digit_t;
    // Eight digits; element 0 is the leftmost digit (digit 1).
    typedef digit_t [7:0] digit_vec_t;
    // Four input bytes; element 0 is the least significant byte.
    typedef logic [3:0][7:0] byte_vec_t;

    // One formatted result.
    typedef struct packed {
        logic [11:0] mask;
        digit_vec_t  digits;
    } result_t;

    localparam digit_t DIGIT_BLANK = 5'd16;
    localparam digit_t DIGIT_DASH  = 5'd17;

    // Format codes.
    localparam logic [7:0] FMT_DEC_MAX    = 8'h06;
    localparam logic [7:0] FMT_POINT_MIN  = 8'h01;
    localparam logic [7:0] FMT_POINT_MAX  = 8'h05;
    localparam logic [7:0] FMT_LAYOUT_MIN = 8'h07;
    localparam logic [7:0] FMT_HEX        = 8'h09;
    localparam logic [7:0] FMT_LAYOUT_MAX = 8'h13;

    localparam logic [2:0] LEN_MAX  = 3'd4;
    localparam logic [2:0] SRC_NONE = 3'd4;

    localparam logic [7:0] SIGN_BIT  = 8'h80;
    localparam logic [7:0] VALUE_BITS = 8'h7f;

    // Lengths above four are treated as four.
    function automatic logic [2:0] sat_length(input logic [2:0] len);
        sat_length = (len > LEN_MAX) ? LEN_MAX : len;
    endfunction

    // Source byte for each digit pair (element 0 is digits 1-2), per layout.
    function automatic logic [3:0][2:0] layout_src(input logic [3:0] k);
        case (k)
            4'd0:    layout_src = {3'd0, 3'd1, 3'd2, 3'd3};
            4'd1:    layout_src = {3'd1, 3'd2, SRC_NONE, 3'd0};
            4'd3:    layout_src = {3'd0, 3'd1, 3'd2, SRC_NONE};
            4'd4:    layout_src = {3'd0, 3'd1, 3'd2, SRC_NONE};
            4'd5:    layout_src = {3'd0, 3'd1, 3'd2, 3'd3};
            4'd6:    layout_src = {3'd0, 3'd1, 3'd2, SRC_NONE};
            4'd7:    layout_src = {3'd0, 3'd1, SRC_NONE, SRC_NONE};
            4'd8:    layout_src = {3'd0, SRC_NONE, 3'd1, SRC_NONE};
            4'd9:    layout_src = {3'd0, 3'd1, SRC_NONE, SRC_NONE};
            4'd10:   layout_src = {3'd1, 3'd2, SRC_NONE, 3'd0};
            4'd11:   layout_src = {3'd0, SRC_NONE, SRC_NONE, SRC_NONE};
            4'd12:   layout_src = {3'd0, 3'd1, 3'd2, 3'd3};
            default: layout_src = {SRC_NONE, SRC_NONE, SRC_NONE, SRC_NONE};
        endcase
    endfunction

    // Annunciator mask per layout.
    function automatic logic [11:0] layout_mask(input logic [3:0] k);
        case (k)
            4'd0:    layout_mask = 12'h014;
            4'd1:    layout_mask = 12'h350;
            4'd3:    layout_mask = 12'h054;
            4'd4:    layout_mask = 12'h014;
            4'd5:    layout_mask = 12'h054;
            4'd6:    layout_mask = 12'h0d4;
            4'd8:    layout_mask = 12'hc00;
            4'd9:    layout_mask = 12'h050;
            4'd10:   layout_mask = 12'h310;
            default: layout_mask = 12'h000;
        endcase
    endfunction

endpackage

// ----- design/mlbf_decimal.sv -----
// ---------------------------------------------------------------------------
// mlbf_decimal
// Signed decimal formats: sign extraction, forced zeros, leading blanking
// and decimal point.
// ---------------------------------------------------------------------------
module mlbf_decimal (
    input  mlbf_pkg::byte_vec_t  bytes_in,
    input  logic [7:0]           format_in,
    input  logic [2:0]           length_in,
    output mlbf_pkg::result_t    result
);
    import mlbf_pkg::*;

    byte_vec_t  value;
    logic [2:0] len_sat;
    logic [1:0] sign_idx;
    logic [3:0] nib;
    logic       seen;
    logic [7:0] pos;

    // Sign removal, then left-to-right scan with leading-zero blanking.
    always_comb begin
        value       = bytes_in;
        len_sat     = sat_length(length_in);
        sign_idx    = 2'(len_sat - 3'd1);
        result.mask = '0;
        seen        = 1'b0;
        nib         = '0;
        pos         = '0;
        if ((len_sat != 3'd0) && ((value[sign_idx] & SIGN_BIT) != 8'h00)) begin
            value[sign_idx] = value[sign_idx] & VALUE_BITS;
            result.mask[0]  = 1'b1;
        end
        for (int i = 0; i < 8; i++) begin
            nib = (i % 2 == 0) ? value[3 - i / 2][7:4] : value[3 - i / 2][3:0];
            if ((len_sat == 3'd3) && (i < 2)) begin
                nib = '0;
            end
            if ((len_sat == 3'd2) && (i < 4)) begin
                nib = '0;
            end
            pos = 8'(7 - i);
            if ((nib == 4'd0) && !seen && (pos > format_in)) begin
                result.digits[i] = DIGIT_BLANK;
            end else begin
                result.digits[i] = {1'b0, nib};
                seen             = 1'b1;
            end
        end
        // One decimal point for the fixed-point formats.
        if ((format_in >= FMT_POINT_MIN) && (format_in <= FMT_POINT_MAX)) begin
            result.mask[3'(6 - format_in[2:0])] = 1'b1;
        end
    end

endmodule

// ----- design/mlbf_layout.sv -----
// ---------------------------------------------------------------------------
// mlbf_layout
// Fixed nibble layouts (date, time, tariff), the hex view and the dash
// display for unknown codes.
// ---------------------------------------------------------------------------
module mlbf_layout (
    input  mlbf_pkg::byte_vec_t  bytes_in,
    input  logic [7:0]           format_in,
    input  logic [2:0]           length_in,
    output mlbf_pkg::result_t    result
);
    import mlbf_pkg::*;

    logic [3:0]      k;
    logic [3:0][2:0] src;
    logic [2:0]      len_sat;

    assign k       = 4'(format_in - FMT_LAYOUT_MIN);
    assign src     = layout_src(k);
    assign len_sat = sat_length(length_in);

    // Place nibbles by format; unused digits stay blank, unknown codes show dashes.
    always_comb begin
        result.mask = '0;
        for (int i = 0; i < 8; i++) begin
            result.digits[i] = DIGIT_BLANK;
        end
        if (format_in == FMT_HEX) begin
            // Hex view fills from the right, one byte per pair.
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < len_sat) begin
                    result.digits[6 - 2 * i] = {1'b0, bytes_in[i][7:4]};
                    result.digits[7 - 2 * i] = {1'b0, bytes_in[i][3:0]};
                end
            end
        end else if ((format_in >= FMT_LAYOUT_MIN) && (format_in <= FMT_LAYOUT_MAX)) begin
            for (int p = 0; p < 4; p++) begin
                if (src[p] != SRC_NONE) begin
                    result.digits[2 * p]     = {1'b0, bytes_in[src[p][1:0]][7:4]};
                    result.digits[2 * p + 1] = {1'b0, bytes_in[src[p][1:0]][3:0]};
                end
            end
            result.mask = layout_mask(k);
        end else begin
            for (int i = 0; i < 8; i++) begin
                result.digits[i] = DIGIT_DASH;
            end
        end
    end

endmodule

// ----- design/meter_lcd_bcd_formatter.sv -----
// ---------------------------------------------------------------------------
// meter_lcd_bcd_formatter
// Formats four BCD bytes into eight LCD digit codes and an annunciator mask.
// ---------------------------------------------------------------------------
// Usage:
// Words arrive on the s_ channel: s_tdata carries the four value bytes and
// the byte length, s_tuser carries the display format code. Each accepted
// word yields exactly one result word on the m_ channel, carrying the eight
// digit codes (16 blank, 17 dash) and the twelve-bit segment mask.
// The word is first captured in an input register; the formatting logic sits
// between that register and the result register, which presents the result
// word on the m_ channel.
// One word is taken every cycle while m_tready is high; the rate is set by
// the single pass of formatting logic between the two registers.
// When the receiver stalls, the result register holds its word and the
// input register may still fill, so one further word is absorbed before
// s_tready falls. s_tready depends combinationally on m_tready.
// A synchronous active-low reset empties both registers; the block keeps no
// other state.
// ---------------------------------------------------------------------------
module meter_lcd_bcd_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // byte0 [7:0], byte1 [15:8], byte2 [23:16], byte3 [31:24],
    // length [34:32], zero fill [39:35]
    input  logic [39:0] s_tdata,
    // format [7:0]
    input  logic [7:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // digit1 [4:0], digit2 [9:5], ... digit8 [39:35],
    // segment_mask [51:40], zero fill [55:52]
    output logic [55:0] m_tdata
);
    import mlbf_pkg::*;

    logic       in_valid_reg,  in_valid_next;
    byte_vec_t  in_bytes_reg,  in_bytes_next;
    logic [7:0] in_format_reg, in_format_next;
    logic [2:0] in_length_reg, in_length_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_result_reg, out_result_next;

    logic    out_adv;
    logic    in_adv;
    result_t dec_result;
    result_t lay_result;

    // Stage advance: a stage takes a word when it is empty or draining.
    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = !in_valid_reg || out_adv;
    assign s_tready = in_adv;

    mlbf_decimal u_decimal (
        .bytes_in  (in_bytes_reg),
        .format_in (in_format_reg),
        .length_in (in_length_reg),
        .result    (dec_result)
    );

    mlbf_layout u_layout (
        .bytes_in  (in_bytes_reg),
        .format_in (in_format_reg),
        .length_in (in_length_reg),
        .result    (lay_result)
    );

    // Next values of the input and result registers.
    always_comb begin
        in_valid_next   = in_valid_reg;
        in_bytes_next   = in_bytes_reg;
        in_format_next  = in_format_reg;
        in_length_next  = in_length_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (in_adv) begin
            in_valid_next  = s_tvalid;
            in_bytes_next  = s_tdata[31:0];
            in_format_next = s_tuser;
            in_length_next = s_tdata[34:32];
        end
        if (out_adv) begin
            out_valid_next  = in_valid_reg;
            out_result_next = (in_format_reg <= FMT_DEC_MAX) ? dec_result : lay_result;
        end
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        in_bytes_reg   <= in_bytes_next;
        in_format_reg  <= in_format_next;
        in_length_reg  <= in_length_next;
        out_result_reg <= out_result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_result_reg};

endmodule

// ----- design/mlbf_checker.sv -----
// ---------------------------------------------------------------------------
// mlbf_checker
// Port-level checks of the formatter, bound to the top level.
// ---------------------------------------------------------------------------
module mlbf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    import mlbf_pkg::*;

    // Reset leaves no result word pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A dash in the first digit means the whole display is dashes and the mask is clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:0] == DIGIT_DASH) |->
            (m_tdata[9:5] == DIGIT_DASH) && (m_tdata[14:10] == DIGIT_DASH) &&
            (m_tdata[19:15] == DIGIT_DASH) && (m_tdata[24:20] == DIGIT_DASH) &&
            (m_tdata[29:25] == DIGIT_DASH) && (m_tdata[34:30] == DIGIT_DASH) &&
            (m_tdata[39:35] == DIGIT_DASH) && (m_tdata[51:40] == 12'h000))
        else $error("partial dash display");

    // Every digit code is within the defined set and the fill is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            (m_tdata[4:0] <= DIGIT_DASH) && (m_tdata[9:5] <= DIGIT_DASH) &&
            (m_tdata[14:10] <= DIGIT_DASH) && (m_tdata[19:15] <= DIGIT_DASH) &&
            (m_tdata[24:20] <= DIGIT_DASH) && (m_tdata[29:25] <= DIGIT_DASH) &&
            (m_tdata[34:30] <= DIGIT_DASH) && (m_tdata[39:35] <= DIGIT_DASH) &&
            (m_tdata[55:52] == 4'h0))
        else $error("digit code out of range");

endmodule

bind meter_lcd_bcd_formatter mlbf_checker u_mlbf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
